FILE: design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int CoeffW = 16;
   localparam int SumW   = 17;
   localparam int PowerW = 10;
   localparam int OpW    = 2;

   localparam int DefaultDepth     = 16;
   localparam int DefaultPowerBits = 10;

   localparam logic [OpW-1:0] OpAppendFirst  = 2'd0;
   localparam logic [OpW-1:0] OpAppendSecond = 2'd1;
   localparam logic [OpW-1:0] OpAdd          = 2'd2;

   // one stored term
   typedef struct packed {
      logic signed [CoeffW-1:0] coeff;
      logic [PowerW-1:0]        power;
   } term_type;

endpackage

FILE: design/spa_store.sv
// ----------------------------------------------------------------------------
// spa_store
// Term store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spa_store #(
   parameter int DEPTH = spa_pkg::DefaultDepth,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  spa_pkg::term_type wr_term,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output spa_pkg::term_type rd_term
);
   import spa_pkg::*;

   term_type mem_ff [DEPTH];
   term_type rd_term_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_term;
      end
      if (rd_en) begin
         rd_term_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_term = rd_term_ff;

endmodule

FILE: design/spa_merge.sv
// ----------------------------------------------------------------------------
// spa_merge
// Fill counts, append handling and the merge walk over both term stores.
// ----------------------------------------------------------------------------
module spa_merge #(
   parameter int DEPTH      = spa_pkg::DefaultDepth,
   parameter int POWER_BITS = spa_pkg::DefaultPowerBits,
   parameter int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [spa_pkg::OpW-1:0]         req_operation,
   input  logic signed [spa_pkg::CoeffW-1:0] req_coeff,
   input  logic [spa_pkg::PowerW-1:0]      req_power,
   // store A
   output logic                            a_wr_en,
   output logic [IDX_W-1:0]                a_wr_addr,
   output logic                            a_rd_en,
   output logic [IDX_W-1:0]                a_rd_addr,
   input  spa_pkg::term_type               a_rd_term,
   // store B
   output logic                            b_wr_en,
   output logic [IDX_W-1:0]                b_wr_addr,
   output logic                            b_rd_en,
   output logic [IDX_W-1:0]                b_rd_addr,
   input  spa_pkg::term_type               b_rd_term,
   output spa_pkg::term_type               wr_term,
   // result
   output logic                            rsp_valid,
   output logic signed [spa_pkg::SumW-1:0] rsp_sum_coeff,
   output logic [spa_pkg::PowerW-1:0]      rsp_sum_power,
   output logic                            rsp_last
);
   import spa_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
   localparam logic [PowerW-1:0] PowerMask =
      (POWER_BITS >= PowerW) ? {PowerW{1'b1}} : PowerW'((64'd1 << POWER_BITS) - 64'd1);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRead = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;

   logic                     valid_ff, valid_in;
   logic signed [SumW-1:0]   coeff_ff, coeff_in;
   logic [PowerW-1:0]        power_ff, power_in;
   logic                     last_ff, last_in;

   logic accept, a_has, b_has, take_a, take_b;
   logic signed [SumW-1:0] ca, cb;

   assign accept = start && !busy;
   assign busy   = (state_ff != StIdle);

   assign wr_term.coeff = req_coeff;
   assign wr_term.power = req_power & PowerMask;

   assign a_wr_en   = accept && (req_operation == OpAppendFirst) && (cnt_a_ff < DepthCnt);
   assign b_wr_en   = accept && (req_operation == OpAppendSecond) && (cnt_b_ff < DepthCnt);
   assign a_wr_addr = cnt_a_ff[IDX_W-1:0];
   assign b_wr_addr = cnt_b_ff[IDX_W-1:0];

   assign a_has = (i_ff < cnt_a_ff);
   assign b_has = (j_ff < cnt_b_ff);

   assign a_rd_en   = (state_ff == StRead) && a_has;
   assign b_rd_en   = (state_ff == StRead) && b_has;
   assign a_rd_addr = i_ff[IDX_W-1:0];
   assign b_rd_addr = j_ff[IDX_W-1:0];

   // merge decision on the registered read data
   always_comb begin
      priority if (a_has && b_has) begin
         take_a = (a_rd_term.power >= b_rd_term.power);
         take_b = (a_rd_term.power <= b_rd_term.power);
      end else begin
         take_a = a_has;
         take_b = b_has;
      end
   end

   assign ca = take_a ? SumW'(a_rd_term.coeff) : '0;
   assign cb = take_b ? SumW'(b_rd_term.coeff) : '0;

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      valid_in = 1'b0;
      coeff_in = coeff_ff;
      power_in = power_ff;
      last_in  = last_ff;
      unique case (state_ff)
         StIdle: begin
            if (a_wr_en) cnt_a_in = cnt_a_ff + CntW'(1);
            if (b_wr_en) cnt_b_in = cnt_b_ff + CntW'(1);
            if (accept && (req_operation == OpAdd)
                && ((cnt_a_ff != '0) || (cnt_b_ff != '0))) begin
               i_in     = '0;
               j_in     = '0;
               state_in = StRead;
            end
         end
         StRead: begin
            state_in = StEmit;
         end
         StEmit: begin
            i_in     = i_ff + CntW'(take_a);
            j_in     = j_ff + CntW'(take_b);
            valid_in = 1'b1;
            coeff_in = ca + cb;
            power_in = take_a ? a_rd_term.power : b_rd_term.power;
            last_in  = (i_in == cnt_a_ff) && (j_in == cnt_b_ff);
            if (last_in) begin
               cnt_a_in = '0;
               cnt_b_in = '0;
               state_in = StIdle;
            end else begin
               state_in = StRead;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      coeff_ff <= coeff_in;
      power_ff <= power_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_sum_coeff = coeff_ff;
   assign rsp_sum_power = power_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: design/sparse_polynomial_adder.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Merges two sparse polynomials, held term by term in two stores, by power.
// ----------------------------------------------------------------------------
// Usage:
//  - A command transaction is taken on a rising edge with start high and busy
//    low. req_operation selects: append to the first store, append to the
//    second store, or add. Appends never raise busy; an append to a full
//    store (DEPTH terms) is dropped.
//  - An add walks both stores from their first term. For each result term
//    the controller first reads both stores, then compares powers and
//    registers the term; busy stays high until the last term is registered.
//    An add on two empty stores returns nothing and leaves busy low.
//  - Each result is shown for one cycle with rsp_valid high; rsp_last marks
//    the final term. The receiver cannot stall, so nothing is held back.
//    Both stores are empty after the last term.
//  - Reset (synchronous) clears the fill counts and the controller; store
//    contents are not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder #(
   parameter int DEPTH      = spa_pkg::DefaultDepth,
   parameter int POWER_BITS = spa_pkg::DefaultPowerBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spa_pkg::OpW-1:0]           req_operation,
   input  logic signed [spa_pkg::CoeffW-1:0] req_coeff,
   input  logic [spa_pkg::PowerW-1:0]        req_power,
   output logic                              rsp_valid,
   output logic signed [spa_pkg::SumW-1:0]   rsp_sum_coeff,
   output logic [spa_pkg::PowerW-1:0]        rsp_sum_power,
   output logic                              rsp_last
);
   import spa_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // store ports; writes only happen while idle, so reads never see a
   // same-cycle write to the same entry
   logic            a_wr_en, a_rd_en, b_wr_en, b_rd_en;
   logic [IdxW-1:0] a_wr_addr, a_rd_addr, b_wr_addr, b_rd_addr;
   term_type        a_rd_term, b_rd_term, wr_term;

   spa_store #(.DEPTH(DEPTH), .IDX_W(IdxW)) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_term (wr_term),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_term (a_rd_term)
   );

   spa_store #(.DEPTH(DEPTH), .IDX_W(IdxW)) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_term (wr_term),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_term (b_rd_term)
   );

   // controller: fill counts, merge walk, result register
   spa_merge #(.DEPTH(DEPTH), .POWER_BITS(POWER_BITS), .IDX_W(IdxW)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_coeff     (req_coeff),
      .req_power     (req_power),
      .a_wr_en       (a_wr_en),
      .a_wr_addr     (a_wr_addr),
      .a_rd_en       (a_rd_en),
      .a_rd_addr     (a_rd_addr),
      .a_rd_term     (a_rd_term),
      .b_wr_en       (b_wr_en),
      .b_wr_addr     (b_wr_addr),
      .b_rd_en       (b_rd_en),
      .b_rd_addr     (b_rd_addr),
      .b_rd_term     (b_rd_term),
      .wr_term       (wr_term),
      .rsp_valid     (rsp_valid),
      .rsp_sum_coeff (rsp_sum_coeff),
      .rsp_sum_power (rsp_sum_power),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: tb/sparse_polynomial_adder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_tb
// Self-checking bench for the sparse polynomial adder. Directed tests cover
// the coefficient and power extremes, cancelling terms, one or both stores
// empty, unsorted powers, the unused command and store overflow. A random
// phase then loads mostly sorted polynomials with shared powers, mixed with
// noise. Each accepted command updates a local predictor, and every result
// term is checked field by field against the oldest expected term.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder_tb;

   import spa_pkg::*;

   localparam int Depth = DefaultDepth;
   // command code that the block does not decode
   localparam logic [OpW-1:0] OpUnused = 2'd3;
   localparam int ItemTarget = 180;
   localparam int MaxPrinted = 40;

   // one expected result term
   typedef struct {
      logic signed [SumW-1:0] coeff;
      logic [PowerW-1:0]      power;
      logic                   last;
   } sum_term_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OpW-1:0]           req_operation;
   logic signed [CoeffW-1:0] req_coeff;
   logic [PowerW-1:0]        req_power;
   logic                     rsp_valid;
   logic signed [SumW-1:0]   rsp_sum_coeff;
   logic [PowerW-1:0]        rsp_sum_power;
   logic                     rsp_last;

   // predictor state: the two term stores as the block should hold them
   term_type     first_terms[$];
   term_type     second_terms[$];
   // result terms still owed by the block, oldest first
   sum_term_type pending_sums[$];

   int error_count   = 0;
   int useful_items  = 0;
   int add_count     = 0;
   int terms_checked = 0;
   int burst_left    = 0;

   sparse_polynomial_adder #(
      .DEPTH     (Depth),
      .POWER_BITS(DefaultPowerBits)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operation(req_operation),
      .req_coeff    (req_coeff),
      .req_power    (req_power),
      .rsp_valid    (rsp_valid),
      .rsp_sum_coeff(rsp_sum_coeff),
      .rsp_sum_power(rsp_sum_power),
      .rsp_last     (rsp_last)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Mismatch reporting: one line per mismatch, capped so a broken block
   // cannot flood the log; every mismatch is still counted.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (error_count < MaxPrinted)
         $display("[%0t] MISMATCH: %s", $time, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // Predictor. Appends go to a store unless it already holds Depth terms.
   // An add merges both stores by power: equal powers sum (zero sums are
   // kept), otherwise the higher power goes first; leftovers follow in load
   // order. The last term carries the last flag, and both stores empty out.
   // ------------------------------------------------------------------------
   task automatic merge_stores();
      sum_term_type merged[$];
      sum_term_type t;
      int i = 0;
      int j = 0;
      while (i < first_terms.size() && j < second_terms.size()) begin
         t.last = 1'b0;
         if (first_terms[i].power == second_terms[j].power) begin
            t.coeff = $signed(first_terms[i].coeff) + $signed(second_terms[j].coeff);
            t.power = first_terms[i].power;
            i++;
            j++;
         end else if (first_terms[i].power > second_terms[j].power) begin
            t.coeff = $signed(first_terms[i].coeff);
            t.power = first_terms[i].power;
            i++;
         end else begin
            t.coeff = $signed(second_terms[j].coeff);
            t.power = second_terms[j].power;
            j++;
         end
         merged.push_back(t);
      end
      for (; i < first_terms.size(); i++) begin
         t.coeff = $signed(first_terms[i].coeff);
         t.power = first_terms[i].power;
         t.last  = 1'b0;
         merged.push_back(t);
      end
      for (; j < second_terms.size(); j++) begin
         t.coeff = $signed(second_terms[j].coeff);
         t.power = second_terms[j].power;
         t.last  = 1'b0;
         merged.push_back(t);
      end
      if (merged.size() > 0)
         merged[merged.size()-1].last = 1'b1;
      foreach (merged[k])
         pending_sums.push_back(merged[k]);
      first_terms.delete();
      second_terms.delete();
   endtask

   task automatic predict_command(input logic [OpW-1:0] op,
                                  input logic signed [CoeffW-1:0] coeff,
                                  input logic [PowerW-1:0] power);
      term_type t;
      t.coeff = coeff;
      t.power = power;
      case (op)
         OpAppendFirst: begin
            if (first_terms.size() < Depth) begin
               first_terms.push_back(t);
               useful_items++;
            end
         end
         OpAppendSecond: begin
            if (second_terms.size() < Depth) begin
               second_terms.push_back(t);
               useful_items++;
            end
         end
         OpAdd: begin
            merge_stores();
            useful_items++;
            add_count++;
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Sender. Commands go out in bursts of random length; between bursts
   // start drops for a random number of cycles (sometimes none). Fields
   // change on the falling edge; a transaction completes on the rising edge
   // where start is high and busy is low. The caller's next action always
   // happens on the following falling edge, so start never lingers high.
   // ------------------------------------------------------------------------
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic send_command(input logic [OpW-1:0] op,
                               input logic signed [CoeffW-1:0] coeff,
                               input logic [PowerW-1:0] power);
      if (burst_left == 0) begin
         // long bursts with no gap now and then
         if ($urandom_range(0, 4) == 0)
            burst_left = $urandom_range(20, 40);
         else
            burst_left = $urandom_range(1, 8);
         pause_sender($urandom_range(0, 6));
      end
      burst_left--;
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_coeff     <= coeff;
      req_power     <= power;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_command(op, coeff, power);
   endtask

   // add command with junk in the ignored fields
   task automatic send_add();
      send_command(OpAdd, CoeffW'($urandom), PowerW'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Result checker: every strobed term is matched with the oldest expected.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      sum_term_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected term coeff=%0d power=%0d last=%b",
                                      rsp_sum_coeff, rsp_sum_power, rsp_last));
         end else begin
            want = pending_sums.pop_front();
            terms_checked++;
            if (rsp_sum_coeff !== want.coeff)
               report_mismatch($sformatf("sum_coeff %0d, expected %0d (power %0d)",
                                         rsp_sum_coeff, want.coeff, want.power));
            if (rsp_sum_power !== want.power)
               report_mismatch($sformatf("sum_power %0d, expected %0d",
                                         rsp_sum_power, want.power));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b (power %0d)",
                                         rsp_last, want.last, want.power));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------------

   // add on two empty stores gives nothing; the unused code is a no-op
   task automatic test_empty_and_unused();
      send_add();
      send_command(OpUnused, 16'sh7FFF, 10'h3FF);
   endtask

   // largest and smallest sums at the top and bottom powers, plus a cancel
   // in the middle that must still come out as a zero term
   task automatic test_coeff_extremes();
      send_command(OpAppendFirst,  16'sh7FFF, 10'd1023);
      send_command(OpAppendSecond, 16'sh7FFF, 10'd1023);
      send_command(OpAppendFirst,  16'sd7,    10'd500);
      send_command(OpAppendSecond, -16'sd7,   10'd500);
      send_command(OpAppendFirst,  16'sh8000, 10'd0);
      send_command(OpAppendSecond, 16'sh8000, 10'd0);
      send_add();
   endtask

   // only one store loaded: it comes out unchanged, in both directions
   task automatic test_single_store();
      send_command(OpAppendSecond, -16'sd1, 10'd9);
      send_add();
      send_command(OpAppendFirst, 16'sd3, 10'd4);
      send_add();
   endtask

   // ascending powers are merged as loaded, not sorted
   task automatic test_unsorted_powers();
      send_command(OpAppendFirst,  16'sd1, 10'd2);
      send_command(OpAppendFirst,  16'sd1, 10'd9);
      send_command(OpAppendSecond, 16'sd1, 10'd5);
      send_add();
   endtask

   // appends past Depth are dropped; first one store, then the other
   task automatic test_store_overflow();
      int n;
      n = $urandom_range(Depth + 1, Depth + 4);
      for (int k = 0; k < n; k++)
         send_command(OpAppendFirst, CoeffW'($urandom), PowerW'(1023 - 7 * k));
      send_command(OpAppendSecond, CoeffW'($urandom), 10'd1002);
      send_add();
      n = $urandom_range(Depth + 1, Depth + 4);
      for (int k = 0; k < n; k++)
         send_command(OpAppendSecond, CoeffW'($urandom), PowerW'(40 - 2 * k));
      send_add();
   endtask

   // ------------------------------------------------------------------------
   // Random tests
   // ------------------------------------------------------------------------

   // Well-formed pair: both polynomials in descending power order, built
   // from one shared walk down the powers so that many powers coincide.
   // Appends to the two stores are interleaved at random.
   task automatic load_sorted_pair(input int n_first, input int n_second);
      logic signed [CoeffW-1:0] f_coeff[$], s_coeff[$];
      logic [PowerW-1:0]        f_power[$], s_power[$];
      logic signed [CoeffW-1:0] c;
      int cur;
      int pick;
      int fi, si;
      cur = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(1023, 200);
      while (f_coeff.size() < n_first || s_coeff.size() < n_second) begin
         if (f_coeff.size() >= n_first)
            pick = 1;
         else if (s_coeff.size() >= n_second)
            pick = 0;
         else
            pick = $urandom_range(0, 2);
         c = CoeffW'($urandom);
         if (pick != 1) begin
            f_coeff.push_back(c);
            f_power.push_back(PowerW'(cur));
         end
         if (pick != 0) begin
            // shared powers often cancel
            if (pick == 2 && $urandom_range(0, 2) == 0)
               s_coeff.push_back(-c);
            else
               s_coeff.push_back(CoeffW'($urandom));
            s_power.push_back(PowerW'(cur));
         end
         if (cur == 0)
            break;
         cur -= $urandom_range(1, 40);
         if (cur < 0)
            cur = 0;
      end
      fi = 0;
      si = 0;
      while (fi < f_coeff.size() || si < s_coeff.size()) begin
         if (si >= s_coeff.size() || (fi < f_coeff.size() && $urandom_range(0, 1))) begin
            send_command(OpAppendFirst, f_coeff[fi], f_power[fi]);
            fi++;
         end else begin
            send_command(OpAppendSecond, s_coeff[si], s_power[si]);
            si++;
         end
      end
   endtask

   task automatic test_random_merges();
      int kind;
      int n;
      while (useful_items < ItemTarget) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            // mostly short polynomials, sometimes long ones of up to Depth terms
            if (kind == 0)
               load_sorted_pair($urandom_range(10, Depth), $urandom_range(10, Depth));
            else
               load_sorted_pair($urandom_range(0, 6), $urandom_range(0, 6));
         end else if (kind == 7) begin
            // noise: any code, any field values
            n = $urandom_range(1, 8);
            repeat (n)
               send_command(OpW'($urandom_range(0, 3)), CoeffW'($urandom),
                            PowerW'($urandom));
         end else if (kind == 8) begin
            // unsorted powers from a tiny range: repeats and reversals
            n = $urandom_range(1, 8);
            repeat (n)
               send_command(OpW'($urandom_range(0, 1)), CoeffW'($urandom),
                            PowerW'($urandom_range(0, 7)));
         end else begin
            // one store overfilled, the other short
            n = $urandom_range(Depth + 1, Depth + 3);
            for (int k = 0; k < n; k++)
               send_command(OpAppendFirst, CoeffW'($urandom), PowerW'(1023 - 3 * k));
            load_sorted_pair(0, $urandom_range(0, 4));
         end
         send_add();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int waited;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OpAppendFirst;
      req_coeff     = '0;
      req_power     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_coeff_extremes();
      test_single_store();
      test_unsorted_powers();
      test_store_overflow();
      test_random_merges();

      // drop start, then drain what is still owed
      pause_sender(1);
      waited = 0;
      while (pending_sums.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_sums.size() > 0) begin
         report_mismatch($sformatf("%0d result terms never arrived",
                                   pending_sums.size()));
         pending_sums.delete();
      end
      // catch any stray terms after the last expected one
      repeat (10) @(posedge clock);

      $display("Run covered %0d counted commands, %0d adds, %0d result terms checked.",
               useful_items, add_count, terms_checked);
      $display("Directed extremes, cancels, empty and single stores, unsorted powers, "
               , "overflow, then random merges with noise.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
